// File: hw/rtl/epic_pkg.sv
// Package: shared constants for the edge pair index codec.
package epic_pkg;

  localparam int VALUE_WIDTH_DEF = 64;
  localparam int PORT_WIDTH      = 64;

  localparam logic FUNC_PAIR   = 1'b0;
  localparam logic FUNC_UNPAIR = 1'b1;

endpackage

// File: hw/rtl/epic_sqrt_stage.sv
// One registered step of the digit-by-digit integer square root.
module epic_sqrt_stage
  import epic_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         advance,
  input  logic                         valid_prev,
  input  logic                         func_prev,
  input  logic [VALUE_WIDTH-1:0]       x_prev,
  input  logic [VALUE_WIDTH-1:0]       y_prev,
  input  logic [(VALUE_WIDTH+4)/2+2:0] rem_prev,
  input  logic [(VALUE_WIDTH+4)/2-1:0] root_prev,
  input  logic [((VALUE_WIDTH+4)/2)*2-1:0] v_prev,
  output logic                         valid,
  output logic                         func,
  output logic [VALUE_WIDTH-1:0]       x,
  output logic [VALUE_WIDTH-1:0]       y,
  output logic [(VALUE_WIDTH+4)/2+2:0] rem,
  output logic [(VALUE_WIDTH+4)/2-1:0] root,
  output logic [((VALUE_WIDTH+4)/2)*2-1:0] v
);

  localparam int RB = (VALUE_WIDTH + 4) / 2;
  localparam int RW = RB + 3;
  localparam int VB = 2 * RB;

  logic [RW-1:0] rem_sh;
  logic [RW-1:0] trial;
  logic          ge;
  logic [RW-1:0] rem_next;
  logic [RB-1:0] root_next;

  always_comb begin
    rem_sh    = {rem_prev[RW-3:0], v_prev[VB-1:VB-2]};
    trial     = RW'({root_prev, 2'b01});
    ge        = (rem_sh >= trial);
    rem_next  = ge ? (rem_sh - trial) : rem_sh;
    root_next = {root_prev[RB-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (advance) begin
      valid <= valid_prev;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      func <= func_prev;
      x    <= x_prev;
      y    <= y_prev;
      rem  <= rem_next;
      root <= root_next;
      v    <= {v_prev[VB-3:0], 2'b00};
    end
  end

endmodule

// File: hw/rtl/edge_pair_index_codec_top.sv
// Top level: pipelined triangular edge index pairing and unpairing.
//
//  channel  | signals                                   | dir
//  item     | item_valid item_ready func first_value    | in
//           | second_value                              |
//  result   | result_valid result_ready result_low      | out
//           | result_high overflow                      |
//
// One beat enters per cycle while the result is not stalled; the pipeline is an
// input register, an order stage, one square-root digit per stage, then factor,
// multiply, combine and final add stages.
// A stalled result holds the whole pipeline; no beat is lost or repeated.
// Reset clears the valid bits only.
module edge_pair_index_codec_top
  import epic_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_ready,
  input  logic                  func,
  input  logic [PORT_WIDTH-1:0] first_value,
  input  logic [PORT_WIDTH-1:0] second_value,
  output logic                  result_valid,
  input  logic                  result_ready,
  output logic [PORT_WIDTH-1:0] result_low,
  output logic [PORT_WIDTH-1:0] result_high,
  output logic                  overflow
);

  localparam int W  = VALUE_WIDTH;
  localparam int RB = (W + 4) / 2;
  localparam int RW = RB + 3;
  localparam int VB = 2 * RB;
  localparam int H  = (W + 1) / 2;

  logic advance;
  assign advance    = !result_valid || result_ready;
  assign item_ready = advance;

  // input register
  logic         s0_valid;
  logic         s0_func;
  logic [W-1:0] s0_a;
  logic [W-1:0] s0_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (advance) begin
      s0_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s0_func <= func;
      s0_a    <= first_value[W-1:0];
      s0_b    <= second_value[W-1:0];
    end
  end

  // order ids (pair only), form 8*idx+1
  logic          s1_valid;
  logic          s1_func;
  logic [W-1:0]  s1_x;
  logic [W-1:0]  s1_y;
  logic [VB-1:0] s1_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= s0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_func <= s0_func;
      if (s0_func == FUNC_UNPAIR || s0_a < s0_b) begin
        s1_x <= s0_a;
        s1_y <= s0_b;
      end else begin
        s1_x <= s0_b;
        s1_y <= s0_a;
      end
      s1_v <= VB'({s0_a, 3'b001});
    end
  end

  // square-root chain
  logic          q_valid [RB+1];
  logic          q_func  [RB+1];
  logic [W-1:0]  q_x     [RB+1];
  logic [W-1:0]  q_y     [RB+1];
  logic [RW-1:0] q_rem   [RB+1];
  logic [RB-1:0] q_root  [RB+1];
  logic [VB-1:0] q_v     [RB+1];

  assign q_valid[0] = s1_valid;
  assign q_func[0]  = s1_func;
  assign q_x[0]     = s1_x;
  assign q_y[0]     = s1_y;
  assign q_rem[0]   = '0;
  assign q_root[0]  = '0;
  assign q_v[0]     = s1_v;

  for (genvar k = 0; k < RB; k++) begin : g_sqrt
    epic_sqrt_stage #(.VALUE_WIDTH(W)) u_step (
      .clk        (clk),
      .rst        (rst),
      .advance    (advance),
      .valid_prev (q_valid[k]),
      .func_prev  (q_func[k]),
      .x_prev     (q_x[k]),
      .y_prev     (q_y[k]),
      .rem_prev   (q_rem[k]),
      .root_prev  (q_root[k]),
      .v_prev     (q_v[k]),
      .valid      (q_valid[k+1]),
      .func       (q_func[k+1]),
      .x          (q_x[k+1]),
      .y          (q_y[k+1]),
      .rem        (q_rem[k+1]),
      .root       (q_root[k+1]),
      .v          (q_v[k+1])
    );
  end

  // triangular factors
  logic [RB:0]  root_inc;
  logic [W-1:0] j_sel;
  logic [W-1:0] fa_next;
  logic [W-1:0] fb_next;

  always_comb begin
    root_inc = {1'b0, q_root[RB]} + (RB+1)'(1);
    j_sel    = (q_func[RB] == FUNC_UNPAIR) ? W'(root_inc[RB:1]) : q_y[RB];
    if (j_sel == '0) begin
      fa_next = '0;
      fb_next = '0;
    end else if (!j_sel[0]) begin
      fa_next = j_sel >> 1;
      fb_next = j_sel - W'(1);
    end else begin
      fa_next = j_sel;
      fb_next = (j_sel - W'(1)) >> 1;
    end
  end

  logic         t_valid;
  logic         t_func;
  logic [W-1:0] t_x;
  logic [W-1:0] t_j;
  logic [2*H-1:0] t_fa;
  logic [2*H-1:0] t_fb;

  always_ff @(posedge clk) begin
    if (rst) begin
      t_valid <= 1'b0;
    end else if (advance) begin
      t_valid <= q_valid[RB];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      t_func <= q_func[RB];
      t_x    <= q_x[RB];
      t_j    <= j_sel;
      t_fa   <= (2*H)'(fa_next);
      t_fb   <= (2*H)'(fb_next);
    end
  end

  // partial products
  logic           p_valid;
  logic           p_func;
  logic [W-1:0]   p_x;
  logic [W-1:0]   p_j;
  logic [2*H-1:0] p00;
  logic [2*H-1:0] p01;
  logic [2*H-1:0] p10;
  logic [2*H-1:0] p11;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (advance) begin
      p_valid <= t_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      p_func <= t_func;
      p_x    <= t_x;
      p_j    <= t_j;
      p00    <= t_fa[H-1:0]   * t_fb[H-1:0];
      p01    <= t_fa[H-1:0]   * t_fb[2*H-1:H];
      p10    <= t_fa[2*H-1:H] * t_fb[H-1:0];
      p11    <= t_fa[2*H-1:H] * t_fb[2*H-1:H];
    end
  end

  // combine
  logic           c_valid;
  logic           c_func;
  logic [W-1:0]   c_x;
  logic [W-1:0]   c_j;
  logic [4*H-1:0] c_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (advance) begin
      c_valid <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      c_func <= p_func;
      c_x    <= p_x;
      c_j    <= p_j;
      c_prod <= {p11, p00} + ((4*H)'(p01) << H) + ((4*H)'(p10) << H);
    end
  end

  // final add and output register
  logic         prod_wide;
  logic [W:0]   pair_sum;
  logic         ovf_next;
  logic [W-1:0] low_next;
  logic [W-1:0] high_next;

  always_comb begin
    prod_wide = |(c_prod >> W);
    pair_sum  = {1'b0, c_prod[W-1:0]} + {1'b0, c_x};
    if (c_func == FUNC_UNPAIR) begin
      ovf_next  = 1'b0;
      low_next  = c_x - c_prod[W-1:0];
      high_next = c_j;
    end else begin
      ovf_next  = prod_wide || pair_sum[W];
      low_next  = ovf_next ? '0 : pair_sum[W-1:0];
      high_next = '0;
    end
  end

  logic out_func;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_func    <= c_func;
      overflow    <= ovf_next;
      result_low  <= PORT_WIDTH'(low_next);
      result_high <= PORT_WIDTH'(high_next);
    end
  end

  a_ovf_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && overflow |-> result_low == '0 && result_high == '0)
    else $error("overflow beat carries nonzero result");

  a_unpair_no_ovf: assert property (@(posedge clk) disable iff (rst)
    result_valid && out_func == FUNC_UNPAIR |-> !overflow)
    else $error("unpair beat flags overflow");

  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |-> !item_ready)
    else $error("input taken while output stalled");

endmodule
